### hw/rtl/p2dev_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// p2dev_pkg
// Shared constants, codes and the saturating helper of the bivariate polynomial
// evaluator.
// ----------------------------------------------------------------------------
package p2dev_pkg;

  localparam int COEF_W = 32;   // Q16.16 coefficient
  localparam int POS_W  = 16;   // Q2.14 position
  localparam int RES_W  = 48;   // Q24.24 result
  localparam int VAR_W  = 5;
  localparam int FRAC_SH = 14;  // fraction bits of positions and y powers
  localparam int RND_HALF = 8192;
  localparam int Y_ONE = 16384;
  localparam int PERT_RND_HALF = 32768;

  // Opcodes of an input word
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  // Configuration register indexes (paddr[3:2])
  localparam logic [1:0] REG_NUM_X_TERMS = 2'd0;
  localparam logic [1:0] REG_NUM_Y_TERMS = 2'd1;
  localparam logic [1:0] REG_REL_PERTURB = 2'd2;
  localparam logic [1:0] REG_PERTURB_STEP = 2'd3;

  localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};
  localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  // 48-bit add, clamped to the signed range
  function automatic logic signed [RES_W-1:0] sat_add48(
    input logic signed [RES_W-1:0] a,
    input logic signed [RES_W-1:0] b
  );
    logic [RES_W:0] s;
    s = {a[RES_W-1], a} + {b[RES_W-1], b};
    if (s[RES_W] != s[RES_W-1]) begin
      return s[RES_W] ? RES_MIN : RES_MAX;
    end
    return s[RES_W-1:0];
  endfunction

endpackage
`default_nettype wire

### hw/rtl/poly2d_eval_with_perturbations_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// poly2d_eval_with_perturbations_top
// Bivariate fixed-point polynomial evaluator with per-coefficient
// perturbation outputs, built around a coefficient RAM and a shared
// multiplier.
// ----------------------------------------------------------------------------
// A write word stores one Q16.16 coefficient into the coefficient RAM. An
// evaluate word returns the Q24.24 value of the
// polynomial at (x, y) and, when perturbation is requested, one more word per
// used coefficient with that coefficient raised by its perturbation; the
// final word of an evaluation carries last. Before each perturbed word the
// sequencer reads the coefficient and forms its perturbed value (PREP_RD,
// PREP_MUL, PREP_ADD) with a separate multiply by the step. A stalled output
// register holds the sequencer until it drains. The shared
// 48 x (MAX_Y_TERMS+15) multiplier serves the Horner steps in x, the row
// weights and the running power of y, each followed by a rounding stage.
// A new word is taken only once the previous evaluation has handed its
// final result to the output register. Entries never written read back as
// undefined values.
// ----------------------------------------------------------------------------
module poly2d_eval_with_perturbations_top
  import p2dev_pkg::*;
#(
  parameter int MAX_X_TERMS = 4,
  parameter int MAX_Y_TERMS = 4
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // APB-style configuration port
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [3:0]               paddr,
  input  wire logic [31:0]              pwdata,
  output logic      [31:0]              prdata,
  output logic                          pready,
  // input words
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic                     opcode_i,
  input  wire logic [3:0]               coef_index_i,
  input  wire logic signed [COEF_W-1:0] coef_value_i,
  input  wire logic signed [POS_W-1:0]  x_pos_i,
  input  wire logic signed [POS_W-1:0]  y_pos_i,
  input  wire logic                     perturb_enable_i,
  // result words
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [RES_W-1:0]       result_value_o,
  output logic [VAR_W-1:0]              variant_o,
  output logic                          last_o
);

  localparam int DEPTH = MAX_X_TERMS * MAX_Y_TERMS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IXW   = (MAX_X_TERMS > 1) ? $clog2(MAX_X_TERMS) : 1;
  localparam int JYW   = (MAX_Y_TERMS > 1) ? $clog2(MAX_Y_TERMS) : 1;
  // |y^j| stays within 2^(14+j) in Q.14
  localparam int YP_W  = MAX_Y_TERMS + 15;
  localparam int B_W   = YP_W;
  localparam int PW    = RES_W + B_W;
  localparam int RTOP  = RES_W - 1 + FRAC_SH;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP_RD,
    ST_PREP_MUL,
    ST_PREP_ADD,
    ST_ROW,
    ST_ADD,
    ST_XMUL,
    ST_XRND,
    ST_YMUL,
    ST_TRND,
    ST_VACC,
    ST_YRND,
    ST_EMIT
  } state_e;

  // configuration registers
  logic [2:0]               num_x_q;
  logic [2:0]               num_y_q;
  logic                     rel_q;
  logic signed [COEF_W-1:0] step_q;

  // coefficient RAM
  logic signed [COEF_W-1:0] coef_mem [DEPTH];
  logic signed [COEF_W-1:0] rdata_q;
  logic                     mem_we;
  logic [AW-1:0]            wr_addr;
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic [JYW-1:0]           rd_row;
  logic [IXW-1:0]           rd_col;

  // sequencer and datapath
  state_e                   state_q;
  logic signed [POS_W-1:0]  x_q;
  logic signed [POS_W-1:0]  y_q;
  logic                     pert_q;
  logic [IXW-1:0]           nx_last_q;
  logic [JYW-1:0]           ny_last_q;
  logic [IXW-1:0]           i_q;
  logic [JYW-1:0]           j_q;
  logic [IXW-1:0]           pi_q;
  logic [JYW-1:0]           pj_q;
  logic                     pvar_q;
  logic [VAR_W-1:0]         var_q;
  logic signed [RES_W-1:0]  s_q;
  logic signed [RES_W-1:0]  v_q;
  logic signed [YP_W-1:0]   yp_q;
  logic signed [PW-1:0]     prod_q;
  logic signed [COEF_W-1:0] c_q;
  logic signed [63:0]       pprod_q;
  logic signed [COEF_W-1:0] pc_q;

  logic signed [RES_W-1:0]  out_value_q;
  logic [VAR_W-1:0]         out_var_q;
  logic                     out_last_q;
  logic                     out_valid_q;

  logic [IXW-1:0]           nx_last;
  logic [JYW-1:0]           ny_last;
  logic                     cfg_wr;
  logic                     in_acc;
  logic signed [RES_W-1:0]  mul_a;
  logic signed [B_W-1:0]    mul_b;
  logic signed [PW-1:0]     mul_p;
  logic signed [PW:0]       rnd_sum;
  logic [PW-RTOP:0]         rnd_top;
  logic signed [RES_W-1:0]  rnd_res;
  logic                     hit;
  logic signed [COEF_W-1:0] c_sel;
  logic signed [63:0]       pround;
  logic signed [RES_W-1:0]  pdelta;
  logic [RES_W:0]           psum;
  logic signed [COEF_W-1:0] pc_sat;
  logic                     res_last;
  logic                     emit_go;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3:2])
      REG_NUM_X_TERMS:  prdata = {29'd0, num_x_q};
      REG_NUM_Y_TERMS:  prdata = {29'd0, num_y_q};
      REG_REL_PERTURB:  prdata = {31'd0, rel_q};
      REG_PERTURB_STEP: prdata = step_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_x_q <= 3'd1;
      num_y_q <= 3'd1;
      rel_q   <= 1'b0;
      step_q  <= 32'sd66;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_NUM_X_TERMS:  num_x_q <= pwdata[2:0];
        REG_NUM_Y_TERMS:  num_y_q <= pwdata[2:0];
        REG_REL_PERTURB:  rel_q   <= pwdata[0];
        REG_PERTURB_STEP: step_q  <= pwdata;
      endcase
    end
  end

  // term counts: zero acts as one, large values clamp to the table size
  always_comb begin
    if (num_x_q == 3'd0) begin
      nx_last = '0;
    end else if (int'(num_x_q) >= MAX_X_TERMS) begin
      nx_last = IXW'(MAX_X_TERMS - 1);
    end else begin
      nx_last = IXW'(int'(num_x_q) - 1);
    end
    if (num_y_q == 3'd0) begin
      ny_last = '0;
    end else if (int'(num_y_q) >= MAX_Y_TERMS) begin
      ny_last = JYW'(MAX_Y_TERMS - 1);
    end else begin
      ny_last = JYW'(int'(num_y_q) - 1);
    end
  end

  // ---------------------------------------------------------------------------
  // coefficient RAM, one write and one registered read port
  // ---------------------------------------------------------------------------
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign mem_we     = in_acc && (opcode_i == OP_WRITE) && (int'(coef_index_i) < DEPTH);
  assign wr_addr    = AW'(coef_index_i);

  always_comb begin
    rd_en  = 1'b0;
    rd_row = j_q;
    rd_col = i_q - IXW'(1);
    unique case (state_q)
      ST_PREP_RD: begin
        rd_en  = 1'b1;
        rd_row = pj_q;
        rd_col = pi_q;
      end
      ST_ROW: begin
        rd_en  = 1'b1;
        rd_col = nx_last_q;
      end
      ST_XMUL: begin
        rd_en = 1'b1;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  assign rd_addr = AW'(int'(rd_row) * MAX_X_TERMS + int'(rd_col));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      coef_mem[wr_addr] <= coef_value_i;
    end
    if (rd_en) begin
      rdata_q <= coef_mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // shared multiplier and rounding
  // ---------------------------------------------------------------------------
  always_comb begin
    mul_a = s_q;
    mul_b = B_W'(x_q);
    unique case (state_q)
      ST_YMUL: mul_b = yp_q;
      ST_VACC: begin
        mul_a = RES_W'(yp_q);
        mul_b = B_W'(y_q);
      end
      default: begin
        mul_a = s_q;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // round half up, drop 14 fraction bits, clamp to 48 bits
  assign rnd_sum = (PW+1)'(prod_q) + (PW+1)'(RND_HALF);
  assign rnd_top = rnd_sum[PW:RTOP];

  always_comb begin
    if ((&rnd_top) || !(|rnd_top)) begin
      rnd_res = rnd_sum[RTOP:FRAC_SH];
    end else begin
      rnd_res = rnd_sum[PW] ? RES_MIN : RES_MAX;
    end
  end

  // perturbed coefficient
  assign pround = pprod_q + 64'(PERT_RND_HALF);
  assign pdelta = (rel_q && (c_q != '0)) ? pround[63:16] : RES_W'(step_q);
  assign psum   = {{(RES_W-COEF_W+1){c_q[COEF_W-1]}}, c_q} + {pdelta[RES_W-1], pdelta};

  always_comb begin
    if ((&psum[RES_W:COEF_W-1]) || !(|psum[RES_W:COEF_W-1])) begin
      pc_sat = psum[COEF_W-1:0];
    end else begin
      pc_sat = psum[RES_W] ? COEF_MIN : COEF_MAX;
    end
  end

  assign hit   = pvar_q && (j_q == pj_q) && (i_q == pi_q);
  assign c_sel = hit ? pc_q : rdata_q;

  assign res_last = pvar_q ? ((pj_q == ny_last_q) && (pi_q == nx_last_q)) : !pert_q;

  // output register free or draining this cycle
  assign emit_go = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      x_q         <= '0;
      y_q         <= '0;
      pert_q      <= 1'b0;
      nx_last_q   <= '0;
      ny_last_q   <= '0;
      i_q         <= '0;
      j_q         <= '0;
      pi_q        <= '0;
      pj_q        <= '0;
      pvar_q      <= 1'b0;
      var_q       <= '0;
      s_q         <= '0;
      v_q         <= '0;
      yp_q        <= '0;
      prod_q      <= '0;
      c_q         <= '0;
      pprod_q     <= '0;
      pc_q        <= '0;
      out_value_q <= '0;
      out_var_q   <= '0;
      out_last_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && (opcode_i == OP_EVAL)) begin
            x_q       <= x_pos_i;
            y_q       <= y_pos_i;
            pert_q    <= perturb_enable_i;
            nx_last_q <= nx_last;
            ny_last_q <= ny_last;
            pvar_q    <= 1'b0;
            var_q     <= '0;
            v_q       <= '0;
            yp_q      <= YP_W'(Y_ONE);
            j_q       <= '0;
            state_q   <= ST_ROW;
          end
        end
        ST_PREP_RD: begin
          state_q <= ST_PREP_MUL;
        end
        ST_PREP_MUL: begin
          c_q     <= rdata_q;
          pprod_q <= rdata_q * step_q;
          state_q <= ST_PREP_ADD;
        end
        ST_PREP_ADD: begin
          pc_q    <= pc_sat;
          state_q <= ST_ROW;
        end
        ST_ROW: begin
          s_q     <= '0;
          i_q     <= nx_last_q;
          state_q <= ST_ADD;
        end
        ST_ADD: begin
          s_q     <= sat_add48(s_q, {{(RES_W-COEF_W-8){c_sel[COEF_W-1]}}, c_sel, 8'h00});
          state_q <= (i_q != '0) ? ST_XMUL : ST_YMUL;
        end
        ST_XMUL: begin
          prod_q  <= mul_p;
          i_q     <= i_q - IXW'(1);
          state_q <= ST_XRND;
        end
        ST_XRND: begin
          s_q     <= rnd_res;
          state_q <= ST_ADD;
        end
        ST_YMUL: begin
          prod_q  <= mul_p;
          state_q <= ST_TRND;
        end
        ST_TRND: begin
          s_q     <= rnd_res;
          state_q <= ST_VACC;
        end
        ST_VACC: begin
          v_q     <= sat_add48(v_q, s_q);
          prod_q  <= mul_p;
          state_q <= (j_q == ny_last_q) ? ST_EMIT : ST_YRND;
        end
        ST_YRND: begin
          yp_q    <= rnd_res[YP_W-1:0];
          j_q     <= j_q + JYW'(1);
          state_q <= ST_ROW;
        end
        ST_EMIT: begin
          if (emit_go) begin
            out_value_q <= v_q;
            out_var_q   <= var_q;
            out_last_q  <= res_last;
            if (res_last) begin
              state_q <= ST_IDLE;
            end else begin
              // step to the next coefficient, row by row
              if (!pvar_q) begin
                pi_q <= '0;
                pj_q <= '0;
              end else if (pi_q == nx_last_q) begin
                pi_q <= '0;
                pj_q <= pj_q + JYW'(1);
              end else begin
                pi_q <= pi_q + IXW'(1);
              end
              pvar_q  <= 1'b1;
              var_q   <= var_q + VAR_W'(1);
              v_q     <= '0;
              yp_q    <= YP_W'(Y_ONE);
              j_q     <= '0;
              state_q <= ST_PREP_RD;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_value_q;
  assign variant_o      = out_var_q;
  assign last_o         = out_last_q;

endmodule
`default_nettype wire

### tb/poly2d_eval_with_perturbations_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poly2d_eval_with_perturbations_top_tb
// Self-checking bench for the bivariate polynomial evaluator. Coefficient
// writes and evaluate words go in over valid/ready. Result words are checked
// against a fixed-point Horner model held in the bench. Register settings
// are changed over APB between phases. Both sides stall at random, and one
// long output stall backs the block up into its input.
// ----------------------------------------------------------------------------
module poly2d_eval_with_perturbations_top_tb;
  import p2dev_pkg::*;

  localparam int MAX_X = 4;
  localparam int MAX_Y = 4;
  localparam int QUIET_CYCLES = 80;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int SEG_N = 6;
  localparam int SEG_WORDS = 38;
  localparam int HOLD_CYCLES = 600;
  localparam longint RES_HI = (longint'(1) <<< (RES_W - 1)) - 1;
  localparam longint RES_LO = -RES_HI - 1;

  typedef struct {
    logic signed [RES_W-1:0] value;
    logic [VAR_W-1:0]        variant;
    logic                    last;
  } result_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e               kind;
    logic [1:0]              reg_idx;
    logic [31:0]             data;
    logic                    op;
    logic [3:0]              idx;
    logic signed [COEF_W-1:0] coef;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic                    pe;
    bit                      typed;
    logic signed [RES_W-1:0] exp0;
    logic signed [RES_W-1:0] exp1;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic opcode_i = OP_WRITE;
  logic [3:0] coef_index_i = '0;
  logic signed [COEF_W-1:0] coef_value_i = '0;
  logic signed [POS_W-1:0] x_pos_i = '0;
  logic signed [POS_W-1:0] y_pos_i = '0;
  logic perturb_enable_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [RES_W-1:0] result_value_o;
  logic [VAR_W-1:0] variant_o;
  logic last_o;

  // bench copy of the block state
  logic signed [COEF_W-1:0] coef_mem [MAX_X*MAX_Y];
  logic [2:0]               nx_q = 3'd1;
  logic [2:0]               ny_q = 3'd1;
  logic                     rel_q = 1'b0;
  logic signed [31:0]       step_q = 32'sd66;

  result_t pending_q[$];
  row_t    plan_q[$];

  int err_cnt = 0;
  int rx_count = 0;
  int words_sent = 0;
  int evals_sent = 0;
  int reg_writes = 0;
  int cycle_cnt = 0;
  int tx_idle_pct = 32;
  int rx_idle_pct = 56;
  bit hold_arm = 1'b0;

  poly2d_eval_with_perturbations_top #(
    .MAX_X_TERMS(MAX_X),
    .MAX_Y_TERMS(MAX_Y)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .coef_index_i    (coef_index_i),
    .coef_value_i    (coef_value_i),
    .x_pos_i         (x_pos_i),
    .y_pos_i         (y_pos_i),
    .perturb_enable_i(perturb_enable_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_value_o  (result_value_o),
    .variant_o       (variant_o),
    .last_o          (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // fixed-point model
  // --------------------------------------------------------------------------
  function automatic longint sat_res(longint v);
    if (v > RES_HI) return RES_HI;
    if (v < RES_LO) return RES_LO;
    return v;
  endfunction

  // round(a*b / 2^14), saturating; a product past 2^62 saturates outright
  function automatic longint mul_round(longint a, longint b);
    longint unsigned ua;
    longint unsigned ub;
    bit neg;
    longint p;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    neg = (a < 0) != (b < 0);
    if (ua != 0 && ub > (64'd1 << 62) / ua) return neg ? RES_LO : RES_HI;
    p = longint'(ua * ub);
    if (neg) p = -p;
    return sat_res((p + RND_HALF) >>> FRAC_SH);
  endfunction

  function automatic longint perturb_coef(longint c);
    longint st;
    longint d;
    longint r;
    st = step_q;
    if (rel_q && c != 0) d = (c * st + PERT_RND_HALF) >>> 16;
    else d = st;
    r = c + d;
    if (r > COEF_MAX) r = COEF_MAX;
    if (r < COEF_MIN) r = COEF_MIN;
    return r;
  endfunction

  function automatic int clamp_terms(logic [2:0] v, int maxv);
    if (v < 1) return 1;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  // pk is the dense index of the raised coefficient, -1 for none
  function automatic longint poly_value(int nx, int ny, longint x, longint y,
                                        int pk, longint pc);
    longint val;
    longint yp;
    longint s;
    longint c;
    val = 0;
    yp = Y_ONE;
    for (int j = 0; j < ny; j++) begin
      s = 0;
      for (int i = nx - 1; i >= 0; i--) begin
        c = coef_mem[j*MAX_X + i];
        if (j*nx + i == pk) c = pc;
        s = sat_res(s + c * 256);
        if (i > 0) s = mul_round(s, x);
      end
      val = sat_res(val + mul_round(yp, s));
      yp = mul_round(yp, y);
    end
    return val;
  endfunction

  // queue one expected result word at the tail
  function automatic void expect_word(result_t r);
    pending_q.insert(pending_q.size(), r);
  endfunction

  function automatic void predict_word(logic op, logic [3:0] idx,
                                       logic signed [COEF_W-1:0] coef,
                                       logic signed [POS_W-1:0] x,
                                       logic signed [POS_W-1:0] y, logic pe);
    int nx;
    int ny;
    int k;
    longint xl;
    longint yl;
    longint c;
    result_t r;
    if (op == OP_WRITE) begin
      coef_mem[idx] = coef;
      return;
    end
    nx = clamp_terms(nx_q, MAX_X);
    ny = clamp_terms(ny_q, MAX_Y);
    xl = x;
    yl = y;
    r.value = RES_W'(poly_value(nx, ny, xl, yl, -1, 0));
    r.variant = '0;
    r.last = !pe;
    expect_word(r);
    if (!pe) return;
    for (int j = 0; j < ny; j++) begin
      for (int i = 0; i < nx; i++) begin
        k = j*nx + i;
        c = coef_mem[j*MAX_X + i];
        r.value = RES_W'(poly_value(nx, ny, xl, yl, k, perturb_coef(c)));
        r.variant = VAR_W'(k + 1);
        r.last = (j == ny - 1) && (i == nx - 1);
        expect_word(r);
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // directed table
  // --------------------------------------------------------------------------
  function automatic void plan_cfg(logic [1:0] ri, logic [31:0] d);
    row_t r;
    r.kind = ROW_CFG;
    r.reg_idx = ri;
    r.data = d;
    plan_q.insert(plan_q.size(), r);
  endfunction

  function automatic void plan_word(logic op, logic [3:0] idx,
                                    logic signed [COEF_W-1:0] coef,
                                    logic signed [POS_W-1:0] x,
                                    logic signed [POS_W-1:0] y, logic pe,
                                    bit typed = 1'b0,
                                    logic signed [RES_W-1:0] e0 = '0,
                                    logic signed [RES_W-1:0] e1 = '0);
    row_t r;
    r.kind = ROW_WORD;
    r.reg_idx = '0;
    r.data = '0;
    r.op = op;
    r.idx = idx;
    r.coef = coef;
    r.x = x;
    r.y = y;
    r.pe = pe;
    r.typed = typed;
    r.exp0 = e0;
    r.exp1 = e1;
    plan_q.insert(plan_q.size(), r);
  endfunction

  function automatic logic signed [POS_W-1:0] rand_pos();
    logic signed [POS_W-1:0] p;
    p = POS_W'($urandom);
    if ($urandom_range(3) != 0) p = p >>> $urandom_range(1, 3);
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  task automatic send_word(logic op, logic [3:0] idx,
                           logic signed [COEF_W-1:0] coef,
                           logic signed [POS_W-1:0] x,
                           logic signed [POS_W-1:0] y, logic pe);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    coef_index_i <= idx;
    coef_value_i <= coef;
    x_pos_i <= x;
    y_pos_i <= y;
    perturb_enable_i <= pe;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
    if (op == OP_EVAL) evals_sent++;
  endtask

  task automatic write_reg(logic [1:0] ri, logic [31:0] d);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {ri, 2'b00};
    pwdata <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (ri)
      REG_NUM_X_TERMS:  nx_q = d[2:0];
      REG_NUM_Y_TERMS:  ny_q = d[2:0];
      REG_REL_PERTURB:  rel_q = d[0];
      REG_PERTURB_STEP: step_q = d;
      default: ;
    endcase
    reg_writes++;
  endtask

  // block is idle once nothing is pending and a trailing write has settled
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // receiver: random stalls plus one long hold-off
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : ready_gen
    int hold_left;
    bit hold_done;
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else if (hold_arm && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    result_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      rx_count++;
      if (pending_q.size() == 0) begin
        $error("result word with nothing pending: value %h variant %0d last %b",
               result_value_o, variant_o, last_o);
        err_cnt++;
      end else begin
        e = pending_q.pop_front();
        if (result_value_o !== e.value) begin
          $error("result_value: expected %h, got %h", e.value, result_value_o);
          err_cnt++;
        end
        if (variant_o !== e.variant) begin
          $error("variant: expected %0d, got %0d", e.variant, variant_o);
          err_cnt++;
        end
        if (last_o !== e.last) begin
          $error("last: expected %b, got %b", e.last, last_o);
          err_cnt++;
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("poly2d_eval_with_perturbations_top_tb: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    row_t r;
    result_t e;
    logic op;
    logic pe;
    logic [3:0] idx;
    logic signed [COEF_W-1:0] coef;
    logic signed [POS_W-1:0] xp;
    logic signed [POS_W-1:0] yp;
    logic [2:0] nt;

    // after reset: 1 x 1 terms, absolute step of 66
    plan_word(OP_WRITE, 4'd0, 32'sh0001_0000, 16'sh7FFF, 16'sh8000, 1'b1);
    plan_word(OP_EVAL, 4'd15, 32'shDEAD_BEEF, 16'sh0000, 16'sh0000, 1'b0,
              1'b1, 48'sh0000_0100_0000);
    plan_word(OP_EVAL, 4'd9, 32'sh1234_5678, 16'sh4000, 16'sh4000, 1'b1,
              1'b1, 48'sh0000_0100_0000, 48'sh0000_0100_4200);
    // raised coefficient clamps at the Q16.16 ceiling
    plan_word(OP_WRITE, 4'd0, 32'sh7FFF_FFFF, 16'sh0000, 16'sh0000, 1'b0);
    plan_word(OP_EVAL, 4'd0, 32'sh0000_0000, 16'sh7FFF, 16'sh7FFF, 1'b1,
              1'b1, 48'sh007F_FFFF_FF00, 48'sh007F_FFFF_FF00);
    plan_word(OP_WRITE, 4'd0, 32'sh8000_0000, 16'sh1111, 16'sh2222, 1'b1);
    plan_word(OP_EVAL, 4'd3, 32'shFFFF_FFFF, 16'sh8000, 16'sh8000, 1'b1,
              1'b1, 48'shFF80_0000_0000, 48'shFF80_0000_4200);
    // relative step, nonzero and zero coefficient
    plan_cfg(REG_REL_PERTURB, 32'd1);
    plan_word(OP_WRITE, 4'd0, 32'sh0002_0000, 16'sh0000, 16'sh0000, 1'b0);
    plan_word(OP_EVAL, 4'd0, 32'sh0000_0000, 16'sh2000, 16'sh2000, 1'b1);
    plan_word(OP_WRITE, 4'd0, 32'sh0000_0000, 16'sh0000, 16'sh0000, 1'b0);
    plan_word(OP_EVAL, 4'd0, 32'sh0000_0000, 16'sh2000, 16'sh2000, 1'b1);
    // full table, extreme step and positions
    plan_cfg(REG_NUM_X_TERMS, 32'd4);
    plan_cfg(REG_NUM_Y_TERMS, 32'd4);
    plan_cfg(REG_PERTURB_STEP, 32'h7FFF_FFFF);
    plan_word(OP_EVAL, 4'd0, 32'sh0000_0000, 16'sh7FFF, 16'sh7FFF, 1'b1);
    plan_word(OP_EVAL, 4'd0, 32'sh0000_0000, 16'sh8000, 16'sh8000, 1'b1);
    plan_cfg(REG_REL_PERTURB, 32'd0);
    plan_cfg(REG_PERTURB_STEP, 32'h8000_0000);
    plan_word(OP_WRITE, 4'd5, 32'sh7FFF_FFFF, 16'sh0000, 16'sh0000, 1'b0);
    plan_word(OP_EVAL, 4'd0, 32'sh0000_0000, 16'sh8000, 16'sh7FFF, 1'b1);
    // term counts of zero act as one, above four act as four
    plan_cfg(REG_NUM_X_TERMS, 32'd0);
    plan_cfg(REG_NUM_Y_TERMS, 32'd0);
    plan_word(OP_EVAL, 4'd0, 32'sh0000_0000, 16'sh1234, 16'sh4321, 1'b1);
    plan_cfg(REG_NUM_X_TERMS, 32'd7);
    plan_cfg(REG_NUM_Y_TERMS, 32'd5);
    plan_word(OP_EVAL, 4'd0, 32'sh0000_0000, 16'sh2000, 16'shE000, 1'b1);
    plan_cfg(REG_NUM_X_TERMS, 32'd3);
    plan_cfg(REG_NUM_Y_TERMS, 32'd2);
    plan_cfg(REG_REL_PERTURB, 32'd1);
    plan_cfg(REG_PERTURB_STEP, 32'h0000_8000);
    plan_word(OP_WRITE, 4'd6, 32'shFFFF_0000, 16'sh7FFF, 16'sh7FFF, 1'b1);
    plan_word(OP_EVAL, 4'd0, 32'sh0000_0000, 16'sh3000, 16'shC000, 1'b0);
    plan_word(OP_EVAL, 4'd0, 32'sh0000_0000, 16'sh3000, 16'shC000, 1'b1);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every slot gets a value before anything reads it
    for (int s = 0; s < MAX_X*MAX_Y; s++) begin
      coef = $signed($urandom) >>> $urandom_range(0, 24);
      send_word(OP_WRITE, 4'(s), coef, rand_pos(), rand_pos(), 1'($urandom));
      predict_word(OP_WRITE, 4'(s), coef, '0, '0, 1'b0);
    end

    foreach (plan_q[n]) begin
      r = plan_q[n];
      if (r.kind == ROW_CFG) begin
        wait_idle();
        write_reg(r.reg_idx, r.data);
      end else begin
        send_word(r.op, r.idx, r.coef, r.x, r.y, r.pe);
        if (r.typed) begin
          e.value = r.exp0;
          e.variant = '0;
          e.last = !r.pe;
          expect_word(e);
          if (r.pe) begin
            e.value = r.exp1;
            e.variant = VAR_W'(1);
            e.last = 1'b1;
            expect_word(e);
          end
        end else begin
          predict_word(r.op, r.idx, r.coef, r.x, r.y, r.pe);
        end
      end
    end

    for (int seg = 0; seg < SEG_N; seg++) begin
      wait_idle();
      tx_idle_pct = (seg < 2) ? 32 : (seg < 4) ? 56 : 0;
      rx_idle_pct = (seg < 2) ? 56 : (seg < 4) ? 32 : 0;
      // mostly small term counts keep the perturbed runs short
      nt = ($urandom_range(3) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      write_reg(REG_NUM_X_TERMS, {29'd0, nt});
      nt = ($urandom_range(3) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      write_reg(REG_NUM_Y_TERMS, {29'd0, nt});
      write_reg(REG_REL_PERTURB, {31'd0, 1'($urandom)});
      if ($urandom_range(3) == 0) write_reg(REG_PERTURB_STEP, $urandom);
      else write_reg(REG_PERTURB_STEP, $signed($urandom) >>> $urandom_range(16, 30));
      for (int n = 0; n < SEG_WORDS; n++) begin
        if (seg == 4 && n == 8) hold_arm = 1'b1;
        op = ($urandom_range(99) < 35) ? OP_WRITE : OP_EVAL;
        idx = 4'($urandom_range(15));
        coef = $signed($urandom) >>> $urandom_range(0, 24);
        xp = rand_pos();
        yp = rand_pos();
        pe = 1'($urandom);
        send_word(op, idx, coef, xp, yp, pe);
        predict_word(op, idx, coef, xp, yp, pe);
      end
    end

    wait_idle();
    $display("%0d words sent (%0d evaluate), %0d result words checked,",
             words_sent, evals_sent, rx_count);
    $display("%0d register writes over %0d phases, %0d mismatches",
             reg_writes, SEG_N + 1, err_cnt);
    if (err_cnt == 0) begin
      $display("poly2d_eval_with_perturbations_top_tb: done, clean");
    end else begin
      $display("poly2d_eval_with_perturbations_top_tb: done, errors");
    end
    $finish;
  end

endmodule
